// ===== hdl/lfr_pkg.sv =====
package lfr_pkg;

  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned BYTE_W    = 8;

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam logic [7:0] ID_RESET = CH_DASH;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] FRAME_END  = IDX_W'(FRAME_LEN);
  localparam logic [IDX_W-1:0] PAY_FIRST  = 4'd3;
  localparam logic [IDX_W-1:0] NEWID_IDX  = 4'd10;
  localparam logic [IDX_W-1:0] REPLY_LAST = 4'd13;

  localparam logic KIND_APP = 1'b0;
  localparam logic KIND_TX  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_PRD   = 5'b00100,
    S_PLD   = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  typedef struct packed {
    logic       store_id;
    logic       kind;
    logic       last;
    logic [7:0] id_second;
    logic [7:0] id_first;
    logic [7:0] data;
  } result_t;

  function automatic logic id_char_ok(input logic [7:0] c);
    logic ok;
    ok = ((c >= CH_UA) && (c <= CH_UZ)) || (c == CH_DASH) || (c == CH_HASH) ||
         (c == CH_AT) || (c == CH_QUEST) || (c == CH_BSL) || (c == CH_STAR);
    return ok;
  endfunction

  // letters of the change-id command
  function automatic logic [7:0] cmd_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'h43;
      3'd1:    c = 8'h48;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h45;
      3'd4:    c = 8'h56;
      3'd5:    c = 8'h49;
      3'd6:    c = 8'h44;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] k,
                                            input logic [7:0] id1,
                                            input logic [7:0] id2);
    logic [7:0]       c;
    logic [IDX_W-1:0] ci;
    ci = k - PAY_FIRST;
    unique case (k)
      4'd0:             c = CH_A;
      4'd1, 4'd10:      c = id1;
      4'd2, 4'd11:      c = id2;
      4'd3, 4'd4, 4'd5, 4'd6,
      4'd7, 4'd8, 4'd9: c = cmd_char(ci[2:0]);
      4'd12:            c = CH_CR;
      4'd13:            c = CH_LF;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/lfr_ram.sv =====
module lfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lfr_out_stage.sv =====
module lfr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lfr_pkg::result_t  din,
  output logic              free,
  output logic              tvalid,
  input  logic              tready,
  output lfr_pkg::result_t  dout
);

  logic             valid_r;
  logic             valid_nxt;
  lfr_pkg::result_t data_r;

  assign free = !valid_r || tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign tvalid = valid_r;
  assign dout   = data_r;

endmodule

// ===== hdl/llap_frame_receiver_unit.sv =====
// Receives serial characters one transaction at a time and keeps the current
// frame in a 12-byte RAM. An ordinary character is written when accepted. A CR
// or LF closes the frame: the block then reads the 12 stored bytes through the
// single RAM read port to check header and command, and after that emits
// either nine payload bytes (RAM read, then load into the output register)
// or the 14-byte change-id reply (loaded straight into the output register),
// both waiting while the output stage is not free. in_tready is low from the
// frame end until the last result is loaded or the frame is rejected. Bytes
// past the twelfth are dropped; the stored bytes are not cleared between frames.
module llap_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [15:8] cur_id_first, [23:16] cur_id_second
  output logic [1:0]  out_tuser,  // [0] out_kind, [1] store_id
  output logic        out_tlast
);

  localparam int unsigned IW = lfr_pkg::IDX_W;

  lfr_pkg::state_t state_r, state_nxt;

  logic [IW-1:0]  fill_r, fill_nxt;
  logic [IW-1:0]  cnt_r, cnt_nxt;
  logic [lfr_pkg::FRAME_LEN-1:0] vld_r, vld_nxt;
  logic [7:0]     id1_r, id1_nxt;
  logic [7:0]     id2_r, id2_nxt;
  logic [7:0]     nid1_r, nid1_nxt;
  logic           hdr_r, hdr_nxt;
  logic           cmd_r, cmd_nxt;
  logic           mvld_r, mvld_nxt;

  logic           ram_we;
  logic           ram_re;
  logic [7:0]     ram_q;
  logic [7:0]     rd_byte;
  logic [IW-1:0]  b_idx;
  logic [IW-1:0]  c_idx;
  logic           in_acc;
  logic           is_end;

  logic             out_load;
  logic             out_free;
  lfr_pkg::result_t out_din;
  lfr_pkg::result_t out_dout;

  assign in_tready = (state_r == lfr_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_end    = (in_tdata == lfr_pkg::CH_CR) || (in_tdata == lfr_pkg::CH_LF);
  assign ram_we    = in_acc && !is_end && (fill_r < lfr_pkg::FRAME_END);

  // never-written entries read as zero
  assign rd_byte = mvld_r ? ram_q : 8'h00;
  assign b_idx   = cnt_r - 4'd1;
  assign c_idx   = b_idx - lfr_pkg::PAY_FIRST;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    vld_nxt   = vld_r;
    id1_nxt   = id1_r;
    id2_nxt   = id2_r;
    nid1_nxt  = nid1_r;
    hdr_nxt   = hdr_r;
    cmd_nxt   = cmd_r;
    mvld_nxt  = mvld_r;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    out_din   = '0;

    unique case (state_r)
      lfr_pkg::S_IDLE: begin
        if (in_acc) begin
          if (is_end) begin
            fill_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = lfr_pkg::S_CHECK;
          end else if (ram_we) begin
            vld_nxt[fill_r] = 1'b1;
            fill_nxt        = fill_r + 4'd1;
          end
        end
      end

      lfr_pkg::S_CHECK: begin
        if (cnt_r < lfr_pkg::FRAME_END) begin
          ram_re   = 1'b1;
          mvld_nxt = vld_r[cnt_r];
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r != '0) begin
          priority if (b_idx == '0) begin
            hdr_nxt = (rd_byte == lfr_pkg::CH_A);
            cmd_nxt = 1'b1;
          end else if (b_idx == 4'd1) begin
            hdr_nxt = hdr_r && (rd_byte == id1_r);
          end else if (b_idx == 4'd2) begin
            hdr_nxt = hdr_r && (rd_byte == id2_r);
          end else if (b_idx < lfr_pkg::NEWID_IDX) begin
            cmd_nxt = cmd_r && (rd_byte == lfr_pkg::cmd_char(c_idx[2:0]));
          end else if (b_idx == lfr_pkg::NEWID_IDX) begin
            nid1_nxt = rd_byte;
          end else begin
            // last stored byte: decide what the frame was
            priority if (!hdr_r) begin
              state_nxt = lfr_pkg::S_IDLE;
            end else if (cmd_r) begin
              if (lfr_pkg::id_char_ok(nid1_r) && lfr_pkg::id_char_ok(rd_byte)) begin
                id1_nxt   = nid1_r;
                id2_nxt   = rd_byte;
                cnt_nxt   = '0;
                state_nxt = lfr_pkg::S_REPLY;
              end else begin
                state_nxt = lfr_pkg::S_IDLE;
              end
            end else begin
              cnt_nxt   = lfr_pkg::PAY_FIRST;
              state_nxt = lfr_pkg::S_PRD;
            end
          end
        end
      end

      lfr_pkg::S_PRD: begin
        ram_re    = 1'b1;
        mvld_nxt  = vld_r[cnt_r];
        state_nxt = lfr_pkg::S_PLD;
      end

      lfr_pkg::S_PLD: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_din.data      = rd_byte;
          out_din.kind      = lfr_pkg::KIND_APP;
          out_din.store_id  = 1'b0;
          out_din.last      = (cnt_r == lfr_pkg::LAST_IDX);
          out_din.id_first  = id1_r;
          out_din.id_second = id2_r;
          if (cnt_r == lfr_pkg::LAST_IDX) begin
            state_nxt = lfr_pkg::S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 4'd1;
            state_nxt = lfr_pkg::S_PRD;
          end
        end
      end

      lfr_pkg::S_REPLY: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_din.data      = lfr_pkg::reply_byte(cnt_r, id1_r, id2_r);
          out_din.kind      = lfr_pkg::KIND_TX;
          out_din.store_id  = 1'b1;
          out_din.last      = (cnt_r == lfr_pkg::REPLY_LAST);
          out_din.id_first  = id1_r;
          out_din.id_second = id2_r;
          if (cnt_r == lfr_pkg::REPLY_LAST) begin
            state_nxt = lfr_pkg::S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end

      default: begin
        state_nxt = lfr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfr_pkg::S_IDLE;
      fill_r  <= '0;
      cnt_r   <= '0;
      vld_r   <= '0;
      id1_r   <= lfr_pkg::ID_RESET;
      id2_r   <= lfr_pkg::ID_RESET;
      hdr_r   <= 1'b0;
      cmd_r   <= 1'b0;
      mvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      id1_r   <= id1_nxt;
      id2_r   <= id2_nxt;
      hdr_r   <= hdr_nxt;
      cmd_r   <= cmd_nxt;
      mvld_r  <= mvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nid1_r <= nid1_nxt;
  end

  lfr_ram #(
    .WIDTH(lfr_pkg::BYTE_W),
    .DEPTH(lfr_pkg::FRAME_LEN)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (cnt_r),
    .rdata (ram_q)
  );

  lfr_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .din    (out_din),
    .free   (out_free),
    .tvalid (out_tvalid),
    .tready (out_tready),
    .dout   (out_dout)
  );

  assign out_tdata = {out_dout.id_second, out_dout.id_first, out_dout.data};
  assign out_tuser = {out_dout.store_id, out_dout.kind};
  assign out_tlast = out_dout.last;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lfr_pkg::FRAME_END)
    else $error("fill index beyond frame length");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == lfr_pkg::S_IDLE))
    else $error("frame ram written outside idle");

  a_store_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tuser[0])
    else $error("id store flag on a payload transaction");

  // a stalled payload load waits in place after its read
  a_pld_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfr_pkg::S_PLD) |->
      ($past(state_r == lfr_pkg::S_PRD) || $past(state_r == lfr_pkg::S_PLD)))
    else $error("payload load without a preceding ram read");
`endif

endmodule

// ===== tb/sv/llap_frame_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
package llap_frame_scoreboard_pkg;
  import lfr_pkg::*;

  // first letter in the top byte
  localparam logic [55:0] CMD_TEXT = "CHDEVID";

  function automatic logic [7:0] cmd_letter(input int i);
    return CMD_TEXT[8*(6-i) +: 8];
  endfunction

  function automatic logic legal_id_char(input logic [7:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || (c == CH_DASH) || (c == CH_HASH) ||
           (c == CH_AT) || (c == CH_QUEST) || (c == CH_BSL) || (c == CH_STAR);
  endfunction

  function automatic logic [7:0] random_id_char();
    int n;
    n = $urandom_range(0, 31);
    if (n < 26) begin
      return CH_UA + 8'(n);
    end
    case (n)
      26:      return CH_DASH;
      27:      return CH_HASH;
      28:      return CH_AT;
      29:      return CH_QUEST;
      30:      return CH_BSL;
      default: return CH_STAR;
    endcase
  endfunction

  // any byte that does not end the frame
  function automatic logic [7:0] random_data_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ((c == CH_CR) || (c == CH_LF)) begin
      c = c ^ 8'h80;
    end
    return c;
  endfunction

  class llap_frame_scoreboard;
    logic [7:0]  frame_bytes [FRAME_LEN];
    int unsigned fill;
    logic [7:0]  id_first;
    logic [7:0]  id_second;
    result_t     expected_q [$];
    int          errors;
    int          compared;
    int          id_changes;
    int          payloads;
    int          dropped;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      fill       = 0;
      id_first   = ID_RESET;
      id_second  = ID_RESET;
      errors     = 0;
      compared   = 0;
      id_changes = 0;
      payloads   = 0;
      dropped    = 0;
    endfunction

    function void push_char(logic kind, logic [7:0] data, logic last);
      result_t r;
      r.kind      = kind;
      r.data      = data;
      r.last      = last;
      r.store_id  = (kind == KIND_TX);
      r.id_first  = id_first;
      r.id_second = id_second;
      expected_q.push_back(r);
    endfunction

    function void note_rx_byte(logic [7:0] c);
      logic is_cmd;
      if ((c != CH_CR) && (c != CH_LF)) begin
        // overlong frames drop the tail
        if (fill < FRAME_LEN) begin
          frame_bytes[fill] = c;
          fill++;
        end
        return;
      end
      fill = 0;
      if ((frame_bytes[0] != CH_A) || (frame_bytes[1] != id_first) ||
          (frame_bytes[2] != id_second)) begin
        dropped++;
        return;
      end
      is_cmd = 1'b1;
      for (int i = 0; i < 7; i++) begin
        if (frame_bytes[3+i] != cmd_letter(i)) is_cmd = 1'b0;
      end
      if (!is_cmd) begin
        for (int i = 3; i < FRAME_LEN; i++) begin
          push_char(KIND_APP, frame_bytes[i], i == FRAME_LEN - 1);
        end
        payloads++;
        return;
      end
      if (!legal_id_char(frame_bytes[10]) || !legal_id_char(frame_bytes[11])) begin
        dropped++;
        return;
      end
      id_first  = frame_bytes[10];
      id_second = frame_bytes[11];
      push_char(KIND_TX, CH_A, 1'b0);
      push_char(KIND_TX, id_first, 1'b0);
      push_char(KIND_TX, id_second, 1'b0);
      for (int i = 0; i < 7; i++) push_char(KIND_TX, cmd_letter(i), 1'b0);
      push_char(KIND_TX, id_first, 1'b0);
      push_char(KIND_TX, id_second, 1'b0);
      push_char(KIND_TX, CH_CR, 1'b0);
      push_char(KIND_TX, CH_LF, 1'b1);
      id_changes++;
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [23:0] tdata, logic [1:0] tuser, logic tlast);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got tdata %h tuser %b tlast %b",
                 $time, tdata, tuser, tlast);
        return;
      end
      exp_r = expected_q.pop_front();
      compared++;
      compare_field("out_byte", exp_r.data, tdata[7:0]);
      compare_field("cur_id_first", exp_r.id_first, tdata[15:8]);
      compare_field("cur_id_second", exp_r.id_second, tdata[23:16]);
      compare_field("out_kind", exp_r.kind, tuser[0]);
      compare_field("store_id", exp_r.store_id, tuser[1]);
      compare_field("out_last", exp_r.last, tlast);
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_llap_frame_receiver_unit.sv =====
`timescale 1ns / 100ps
module tb_llap_frame_receiver_unit;
  import lfr_pkg::*;
  import llap_frame_scoreboard_pkg::*;

  localparam int N_ITEMS      = 310;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES  = 400;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  llap_frame_scoreboard sb;
  int send_idle_pct = 25;
  int recv_idle_pct = 88;
  int items_sent    = 0;
  int cycle_count   = 0;
  int hold_cnt      = 0;
  bit hold_req      = 1'b0;

  llap_frame_receiver_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side: check, then pick next ready
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tuser, out_tlast);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_rx_byte(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_rx_byte(c);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_rx_byte(q[i]);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_frame();
    logic [7:0] q[$];
    int         sel;
    int         len;
    logic [7:0] term;
    term = $urandom_range(0, 1) ? CH_CR : CH_LF;
    sel  = $urandom_range(0, 99);
    if (sel < 85) begin
      q.push_back(CH_A);
      q.push_back(sb.id_first);
      q.push_back(sb.id_second);
    end
    if (sel < 40) begin
      for (int i = 0; i < 7; i++) q.push_back(cmd_letter(i));
      if (sel < 30) begin
        q.push_back(random_id_char());
        q.push_back(random_id_char());
      end else begin
        // new id mostly illegal
        q.push_back(random_data_char());
        q.push_back($urandom_range(0, 1) ? random_id_char() : random_data_char());
      end
    end else if (sel < 70) begin
      // short frames judge stale bytes, long ones overrun the store
      len = $urandom_range(0, 13);
      repeat (len) q.push_back(random_data_char());
    end else if (sel < 85) begin
      case ($urandom_range(0, 2))
        0:       q[0] = random_data_char();
        1:       q[1] = random_data_char();
        default: q[2] = random_data_char();
      endcase
      repeat (9) q.push_back(random_data_char());
    end else begin
      len = $urandom_range(1, 16);
      repeat (len) q.push_back(8'($urandom_range(0, 255)));
    end
    q.push_back(term);
    send_bytes(q);
  endtask

  initial begin
    logic [7:0] q[$];
    int         phase;
    sb    = new();
    phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty frame right after reset, id change, stale payload, repeat, bad header
    q.push_back(CH_CR);
    q.push_back(CH_A);
    q.push_back(CH_DASH);
    q.push_back(CH_DASH);
    for (int i = 0; i < 7; i++) q.push_back(cmd_letter(i));
    q.push_back(CH_BSL);
    q.push_back(CH_AT);
    q.push_back(CH_CR);
    q.push_back(CH_A);
    q.push_back(CH_BSL);
    q.push_back(CH_AT);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    q.push_back(CH_LF);
    q.push_back(CH_CR);
    q.push_back(8'h62);
    q.push_back(CH_LF);
    send_bytes(q);
    drain_results();

    while (items_sent < N_ITEMS) begin
      if ((phase == 0) && (items_sent >= 120)) begin
        drain_results();
        send_idle_pct = 88;
        recv_idle_pct = 25;
        phase = 1;
      end else if ((phase == 1) && (items_sent >= 215)) begin
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        phase = 2;
      end
      random_frame();
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d rx bytes: %0d id changes, %0d payload frames, %0d frames dropped",
             items_sent, sb.id_changes, sb.payloads, sb.dropped);
    $display("compared %0d results over three idle profiles and a %0d-cycle output hold",
             sb.compared, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
